[hw/rtl/subtractive_random_generator_macros.svh]
// Assertion macros shared by the subtractive random generator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define SRG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/srg_pkg.sv]
// Shared types, constants and arithmetic for the subtractive random generator.
// Depends on nothing; imported by srg_cell, srg_seq and the top level.
package srg_pkg;

	localparam int VALUE_W   = 30;
	localparam int SEED_W    = 28;
	localparam int TABLE_LEN = 55;
	localparam int SCATTER   = 21;
	localparam int TRAIL_TAP = 31;

	// Seeding lengths: scatter fill plus one alignment step, then four warm-up passes
	localparam int SCAT_CYCLES = TABLE_LEN + 1;
	localparam int WARM_CYCLES = 4 * TABLE_LEN;
	localparam int CNT_W       = $clog2(WARM_CYCLES);

	localparam logic [VALUE_W:0]  MODULUS   = (VALUE_W + 1)'(1000000000);
	localparam logic [SEED_W-1:0] SEED_BASE = SEED_W'(161803398);

	// Ring control carried from the sequencer to the cells
	typedef struct packed {
		logic shift; // rotate by one, difference enters at the tail
		logic jump;  // rotate by the scatter stride
		logic ins;   // tail takes the generator value during a jump
		logic emit;  // load the output register with the difference
	} ring_ctrl_t;

	// (a - b) modulo 1e9 for a and b below 1e9
	function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[VALUE_W]) begin
			d = d + MODULUS;
		end
		return d[VALUE_W-1:0];
	endfunction

endpackage

[hw/rtl/srg_cell.sv]
// One entry of the lag ring: holds a value and takes it from a neighbor.
// Depends on srg_pkg.
module srg_cell (
	input  logic                       clk,
	input  srg_pkg::ring_ctrl_t        ctrl,
	input  logic [srg_pkg::VALUE_W-1:0] next_in,
	input  logic [srg_pkg::VALUE_W-1:0] jump_in,
	output logic [srg_pkg::VALUE_W-1:0] data
);
	import srg_pkg::*;

	logic [VALUE_W-1:0] data_q;

	// Advance by one or by the scatter stride, else hold
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= next_in;
		end else if (ctrl.jump) begin
			data_q <= jump_in;
		end
	end

	assign data = data_q;

endmodule

[hw/rtl/srg_seq.sv]
// Sequencer: handshake, seeding schedule and seed sequence generator.
// Depends on srg_pkg and subtractive_random_generator_macros.svh.
`include "subtractive_random_generator_macros.svh"
module srg_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [srg_pkg::SEED_W-1:0]  seed,
	output logic                        out_valid,
	input  logic                        out_ready,
	output srg_pkg::ring_ctrl_t         ctrl,
	output logic [srg_pkg::VALUE_W-1:0] ins_value
);
	import srg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAT = 2'd1;
	localparam logic [1:0] ST_WARM = 2'd2;
	localparam logic [1:0] ST_DRAW = 2'd3;

	localparam logic [CNT_W-1:0] SCAT_LAST = CNT_W'(SCAT_CYCLES - 1);
	localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(WARM_CYCLES - 1);

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               seeded_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] gen_p_q;
	logic [VALUE_W-1:0] gen_n_q;
	logic [SEED_W-1:0]  seed_sat;
	logic               can_emit;
	logic               accept;
	logic               reseed_now;

	// Output register free this cycle
	assign can_emit   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE) && can_emit;
	assign accept     = in_valid && in_ready;
	assign reseed_now = accept && (mode || !seeded_q);
	assign seed_sat   = (seed > SEED_BASE) ? SEED_BASE : seed;

	// Decode ring control from the state
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.shift = accept && !reseed_now;
				ctrl.emit  = accept && !reseed_now;
			end
			ST_SCAT: begin
				ctrl.jump = 1'b1;
				ctrl.ins  = (cnt_q != SCAT_LAST);
			end
			ST_WARM: begin
				ctrl.shift = 1'b1;
			end
			ST_DRAW: begin
				ctrl.shift = can_emit;
				ctrl.emit  = can_emit;
			end
			default: ctrl = '0;
		endcase
	end

	// Advance the state, step counter and seeded flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (reseed_now) begin
						state_q <= ST_SCAT;
						cnt_q   <= '0;
					end
				end
				ST_SCAT: begin
					if (cnt_q == SCAT_LAST) begin
						state_q <= ST_WARM;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WARM: begin
					if (cnt_q == WARM_LAST) begin
						state_q  <= ST_DRAW;
						seeded_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAW: begin
					if (can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold a result until the consumer takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Seed sequence: a0 = base - min(seed, base), a1 = 1, a(k+1) = a(k-1) - a(k)
	always_ff @(posedge clk) begin
		if (reseed_now) begin
			gen_p_q <= VALUE_W'(SEED_BASE - seed_sat);
			gen_n_q <= VALUE_W'(1);
		end else if (ctrl.ins) begin
			gen_p_q <= gen_n_q;
			gen_n_q <= sub_mod(gen_p_q, gen_n_q);
		end
	end

	assign ins_value = gen_p_q;
	assign out_valid = out_valid_q;

	`SRG_ASSERT_IMP(a_no_overwrite, clk, arst_n, ctrl.emit, !out_valid_q || out_ready,
		"result register overwritten while full")
	`SRG_ASSERT_NXT(a_reseed_starts, clk, arst_n, reseed_now, state_q == ST_SCAT,
		"reseed did not start the scatter fill")
	`SRG_ASSERT_NXT(a_warm_done, clk, arst_n, (state_q == ST_WARM) && (cnt_q == WARM_LAST),
		seeded_q && (state_q == ST_DRAW), "warm-up end did not mark the table seeded")
	`SRG_ASSERT_IMP(a_ins_in_scatter, clk, arst_n, ctrl.ins, ctrl.jump && !ctrl.shift,
		"seed value inserted outside the scatter fill")

endmodule

[hw/rtl/subtractive_random_generator.sv]
// Subtractive lagged generator, modulus 1e9, 55-entry ring of cells.
// A draw on a seeded table is registered and shows its result in the cycle after acceptance.
// A reseed (mode 1, or the first item after reset) runs 56 scatter-fill steps,
// 220 warm-up steps and the draw, each one rotation of the cell ring.
// Throughput: one draw per cycle outside reseeds while the consumer takes results.
// Reset clears control and the seeded flag; ring contents stay undefined until seeded.
module subtractive_random_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [srg_pkg::SEED_W-1:0]  seed,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srg_pkg::VALUE_W-1:0] value
);
	import srg_pkg::*;

	ring_ctrl_t         ctrl;
	logic [VALUE_W-1:0] ins_value;
	logic [VALUE_W-1:0] ring [TABLE_LEN];
	logic [VALUE_W-1:0] diff;
	logic [VALUE_W-1:0] tail_jump;
	logic [VALUE_W-1:0] value_q;

	srg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.seed      (seed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl),
		.ins_value (ins_value)
	);

	// Head holds the lead entry, the trail entry sits at a fixed tap
	assign diff = sub_mod(ring[0], ring[TRAIL_TAP]);

	// Tail takes the seed value while filling, else closes the scatter cycle
	assign tail_jump = ctrl.ins ? ins_value : ring[SCATTER - 1];

	for (genvar k = 0; k < TABLE_LEN; k++) begin : g_cell
		if (k == TABLE_LEN - 1) begin : g_tail
			srg_cell u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.next_in (diff),
				.jump_in (tail_jump),
				.data    (ring[k])
			);
		end else begin : g_body
			localparam int JMP = (k + SCATTER) % TABLE_LEN;
			srg_cell u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.next_in (ring[k + 1]),
				.jump_in (ring[JMP]),
				.data    (ring[k])
			);
		end
	end

	// Capture the drawn value
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			value_q <= diff;
		end
	end

	assign value = value_q;

endmodule
